@@ sv/grid_ray_caster_macros.svh @@
// ----------------------------------------------------------------------------
// Grid ray caster assertion macros
// Concurrent assertion wrappers; defining ASSERT_OFF compiles them away.
// ----------------------------------------------------------------------------
`ifndef GRID_RAY_CASTER_MACROS_SVH
`define GRID_RAY_CASTER_MACROS_SVH
`ifndef ASSERT_OFF
`define GRC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GRC_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GRC_ASSERT(lbl, clk, rst, prop, msg)
`define GRC_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

@@ sv/grc_pkg.sv @@
// ----------------------------------------------------------------------------
// Grid ray caster package
// Widths, constants, register indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package grc_pkg;

  localparam int MAP_CELLS = 65536;
  localparam int MAX_STEPS = 512;
  localparam int CELL_BITS = 8;

  localparam int MAP_AW    = $clog2(MAP_CELLS);
  localparam int STEP_W    = $clog2(MAX_STEPS + 1);
  localparam int FRAC_W    = 16;
  localparam int Q_ONE     = 1 << FRAC_W;
  localparam int POS_W     = 24;
  localparam int POS_INT_W = POS_W - FRAC_W;
  localparam int VEC_W     = 18;
  localparam int MW_W      = 9;
  localparam int DW_W      = 13;
  localparam int COL_W     = 12;
  localparam int CIDX_W    = 16;
  localparam int CVAL_W    = 8;
  localparam int HIT_W     = 9;
  localparam int DIST_W    = 23;
  localparam int WF_W      = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Screen coordinate in Q.16: quotient below 2^29, minus one.
  localparam int C_W    = COL_W + FRAC_W + 2;
  localparam int PV_W   = VEC_W + C_W;
  localparam int V_W    = PV_W - FRAC_W + 1;
  localparam int MAG_W  = V_W - 1;
  localparam int LAST_W = FRAC_W + STEP_W;
  localparam int PROD_W = LAST_W + MAG_W;
  localparam int LO_W   = 17;
  localparam int DVD_W  = PROD_W;
  localparam int DVS_W  = MAG_W;
  localparam int COORD_W = $clog2((1 << POS_INT_W) + MAX_STEPS) + 1;
  localparam int IDX_W  = COORD_W + MW_W;

  localparam int DIST_SHIFT = 14;
  localparam int START_DIST = 246;
  localparam int DIST_MAX   = (1 << DIST_W) - 1;

  localparam int MAP_WIDTH_RST     = 64;
  localparam int DISPLAY_WIDTH_RST = 640;
  localparam int DIR_X_RST         = 65536;
  localparam int DIR_Y_RST         = 0;
  localparam int PLANE_X_RST       = 0;
  localparam int PLANE_Y_RST       = 43690;

  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_WIDTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_X         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_Y         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_X         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_X       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_Y       = 3'd7;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_CAST  = 1'b1;

  typedef enum logic [1:0] {
    DIV_SEL_C    = 2'd0,
    DIV_SEL_DIST = 2'd1,
    DIV_SEL_WALL = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     ram_wr;
    logic     load_col;
    logic     div_start;
    div_sel_t div_sel;
    logic     cap_c;
    logic     mul_v;
    logic     set_v;
    logic     init;
    logic     mul_s;
    logic     addr;
    logic     step;
    logic     mul_lo;
    logic     mul_hi;
    logic     cap_d;
    logic     res_none;
    logic     res_start;
    logic     res_hit;
    logic     out_load;
  } grc_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic oob;
    logic cell_nz;
    logic zero_ray;
    logic steps_done;
    logic out_free;
  } grc_sts_t;

endpackage

@@ sv/grc_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module grc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/grc_div.sv @@
// ----------------------------------------------------------------------------
// Grid ray caster divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grc_div
  import grc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DVD_W-1:0] quotient,
  output logic             rem_nz
);

  localparam int DCNT_W = $clog2(DVD_W);

  logic [DCNT_W-1:0] cnt;
  logic [DVS_W-1:0]  rem;
  logic [DVD_W-1:0]  quo;
  logic [DVS_W-1:0]  dvs_r;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              ge;

  assign trial    = {rem, quo[DVD_W-1]};
  assign diff     = trial - {1'b0, dvs_r};
  assign ge       = (trial >= {1'b0, dvs_r});
  assign quotient = quo;
  assign rem_nz   = (rem != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DCNT_W'(1);
        if (cnt == DCNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The dividend shifts out of the top of quo while quotient bits enter below.
  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= dividend;
      rem   <= '0;
      dvs_r <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo <= {quo[DVD_W-2:0], ge};
    end
  end

endmodule

@@ sv/grc_datapath.sv @@
// ----------------------------------------------------------------------------
// Grid ray caster datapath
// Configuration registers, tile map, ray setup, DDA walk and result registers.
// ----------------------------------------------------------------------------
module grc_datapath
  import grc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  grc_cmd_t              cmd,
  output grc_sts_t              sts,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [CIDX_W-1:0]     cell_index,
  input  logic [CVAL_W-1:0]     cell_value,
  input  logic [COL_W-1:0]      column,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [COL_W-1:0]      column_out,
  output logic [HIT_W-1:0]      hit_code,
  output logic [DIST_W-1:0]     distance,
  output logic [WF_W-1:0]       wall_fraction
);

  logic [MW_W-1:0]           map_width;
  logic [MW_W-1:0]           mw_eff;
  logic [DW_W-1:0]           display_width;
  logic [DW_W-1:0]           dw_eff;
  logic [POS_W-1:0]          pos_x;
  logic [POS_W-1:0]          pos_y;
  logic signed [VEC_W-1:0]   dir_x;
  logic signed [VEC_W-1:0]   dir_y;
  logic signed [VEC_W-1:0]   plane_x;
  logic signed [VEC_W-1:0]   plane_y;

  logic [COL_W-1:0]          col_r;
  logic signed [C_W-1:0]     c_val;
  logic signed [PV_W-1:0]    pvx;
  logic signed [PV_W-1:0]    pvy;
  logic signed [V_W-1:0]     vx;
  logic signed [V_W-1:0]     vy;
  logic [MAG_W-1:0]          ax;
  logic [MAG_W-1:0]          ay;
  logic                      vx_neg;
  logic                      vy_neg;
  logic [LAST_W-1:0]         sx;
  logic [LAST_W-1:0]         sy;
  logic [LAST_W-1:0]         last;
  logic [PROD_W-1:0]         px;
  logic [PROD_W-1:0]         py;
  logic [PROD_W-1:0]         wprod;
  logic signed [COORD_W-1:0] mx;
  logic signed [COORD_W-1:0] my;
  logic [STEP_W-1:0]         steps;
  logic                      side;
  logic                      oob;

  logic [HIT_W-1:0]          res_code;
  logic [DIST_W-1:0]         res_dist;
  logic [WF_W-1:0]           res_frac;

  logic [FRAC_W+MAG_W:0]     pxs;
  logic [FRAC_W+MAG_W:0]     pys;
  logic                      x_less;
  logic [COORD_W+MW_W-2:0]   y_off;
  logic [IDX_W-1:0]          idx;
  logic                      oob_c;
  logic [MAG_W-1:0]          oth_mag;
  logic [MAG_W-1:0]          axis_mag;
  logic [LAST_W+LO_W-1:0]    plo;
  logic [PROD_W-LO_W-1:0]    phi;
  logic [DVD_W-1:0]          div_dvd;
  logic [DVS_W-1:0]          div_dvs;
  logic                      div_busy;
  logic                      div_done;
  logic [DVD_W-1:0]          div_q;
  logic                      div_rnz;
  logic [CELL_BITS-1:0]      ram_q;
  logic                      ram_we;
  logic                      oth_neg;
  logic [WF_W-1:0]           pos_oth;
  logic [WF_W-1:0]           qlo;
  logic [WF_W-1:0]           qadj;
  logic [WF_W-1:0]           frac_c;

  assign mw_eff = (map_width == '0) ? MW_W'(1) : map_width;
  assign dw_eff = (display_width == '0) ? DW_W'(1) : display_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width     <= MW_W'(MAP_WIDTH_RST);
      display_width <= DW_W'(DISPLAY_WIDTH_RST);
      pos_x         <= '0;
      pos_y         <= '0;
      dir_x         <= VEC_W'(DIR_X_RST);
      dir_y         <= VEC_W'(DIR_Y_RST);
      plane_x       <= VEC_W'(PLANE_X_RST);
      plane_y       <= VEC_W'(PLANE_Y_RST);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MAP_WIDTH:     map_width     <= cfg_data[MW_W-1:0];
        CFG_DISPLAY_WIDTH: display_width <= cfg_data[DW_W-1:0];
        CFG_POS_X:         pos_x         <= cfg_data[POS_W-1:0];
        CFG_POS_Y:         pos_y         <= cfg_data[POS_W-1:0];
        CFG_DIR_X:         dir_x         <= cfg_data[VEC_W-1:0];
        CFG_DIR_Y:         dir_y         <= cfg_data[VEC_W-1:0];
        CFG_PLANE_X:       plane_x       <= cfg_data[VEC_W-1:0];
        CFG_PLANE_Y:       plane_y       <= cfg_data[VEC_W-1:0];
        default: ;
      endcase
    end
  end

  // Tile map.
  assign ram_we = cmd.ram_wr && ({1'b0, cell_index} < (CIDX_W + 1)'(MAP_CELLS));

  assign y_off = my[COORD_W-2:0] * mw_eff;
  assign idx   = IDX_W'(y_off) + IDX_W'(mx[COORD_W-2:0]);
  assign oob_c = mx[COORD_W-1] || my[COORD_W-1] ||
                 (IDX_W'(mx[COORD_W-2:0]) >= IDX_W'(mw_eff)) ||
                 (idx >= IDX_W'(MAP_CELLS));

  grc_ram #(
    .WIDTH (CELL_BITS),
    .DEPTH (MAP_CELLS)
  ) u_map (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (cell_index[MAP_AW-1:0]),
    .wr_data (cell_value[CELL_BITS-1:0]),
    .rd_en   (cmd.addr),
    .rd_addr (idx[MAP_AW-1:0]),
    .rd_data (ram_q)
  );

  // Shared divider: screen coordinate, distance and wall position.
  assign axis_mag = side ? ay : ax;
  assign oth_mag  = side ? ax : ay;

  always_comb begin
    case (cmd.div_sel)
      DIV_SEL_C: begin
        div_dvd = DVD_W'(col_r) << (FRAC_W + 1);
        div_dvs = DVS_W'(dw_eff);
      end
      DIV_SEL_DIST: begin
        div_dvd = DVD_W'(last) << DIST_SHIFT;
        div_dvs = axis_mag;
      end
      DIV_SEL_WALL: begin
        div_dvd = wprod;
        div_dvs = axis_mag;
      end
      default: begin
        div_dvd = '0;
        div_dvs = '0;
      end
    endcase
  end

  grc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q),
    .rem_nz   (div_rnz)
  );

  // Side distances are compared as sx*ay against sy*ax, kept as running products.
  assign pxs    = sx[FRAC_W:0] * ay;
  assign pys    = sy[FRAC_W:0] * ax;
  assign x_less = (px < py);

  assign plo = last * oth_mag[LO_W-1:0];
  assign phi = last * oth_mag[MAG_W-1:LO_W];

  // Wall coordinate keeps only its fraction; a negative ray rounds toward minus infinity.
  assign oth_neg = side ? vx_neg : vy_neg;
  assign pos_oth = side ? pos_x[WF_W-1:0] : pos_y[WF_W-1:0];
  assign qlo     = div_q[WF_W-1:0];
  assign qadj    = qlo + WF_W'(div_rnz);
  assign frac_c  = oth_neg ? (pos_oth - qadj) : (pos_oth + qlo);

  always_ff @(posedge clk) begin
    if (cmd.load_col) begin
      col_r <= column;
    end
    if (cmd.cap_c) begin
      c_val <= $signed(div_q[C_W-1:0]) - C_W'(Q_ONE);
    end
    if (cmd.mul_v) begin
      pvx <= plane_x * c_val;
      pvy <= plane_y * c_val;
    end
    if (cmd.set_v) begin
      vx <= V_W'(dir_x) + V_W'(pvx >>> FRAC_W);
      vy <= V_W'(dir_y) + V_W'(pvy >>> FRAC_W);
    end
    if (cmd.init) begin
      vx_neg <= vx[V_W-1];
      vy_neg <= vy[V_W-1];
      ax     <= vx[V_W-1] ? MAG_W'(-vx) : MAG_W'(vx);
      ay     <= vy[V_W-1] ? MAG_W'(-vy) : MAG_W'(vy);
      sx     <= vx[V_W-1] ? LAST_W'(pos_x[FRAC_W-1:0])
                          : LAST_W'(Q_ONE) - LAST_W'(pos_x[FRAC_W-1:0]);
      sy     <= vy[V_W-1] ? LAST_W'(pos_y[FRAC_W-1:0])
                          : LAST_W'(Q_ONE) - LAST_W'(pos_y[FRAC_W-1:0]);
      mx     <= $signed(COORD_W'(pos_x[POS_W-1:FRAC_W]));
      my     <= $signed(COORD_W'(pos_y[POS_W-1:FRAC_W]));
      steps  <= '0;
    end
    if (cmd.mul_s) begin
      px <= PROD_W'(pxs);
      py <= PROD_W'(pys);
    end
    if (cmd.addr) begin
      oob <= oob_c;
    end
    if (cmd.step) begin
      steps <= steps + STEP_W'(1);
      if (x_less) begin
        last <= sx;
        sx   <= sx + LAST_W'(Q_ONE);
        px   <= px + (PROD_W'(ay) << FRAC_W);
        mx   <= vx_neg ? (mx - COORD_W'(1)) : (mx + COORD_W'(1));
        side <= 1'b0;
      end else begin
        last <= sy;
        sy   <= sy + LAST_W'(Q_ONE);
        py   <= py + (PROD_W'(ax) << FRAC_W);
        my   <= vy_neg ? (my - COORD_W'(1)) : (my + COORD_W'(1));
        side <= 1'b1;
      end
    end
    if (cmd.mul_lo) begin
      wprod <= PROD_W'(plo);
    end
    if (cmd.mul_hi) begin
      wprod <= wprod + (PROD_W'(phi) << LO_W);
    end
    if (cmd.cap_d) begin
      res_dist <= (div_q > DVD_W'(DIST_MAX)) ? DIST_W'(DIST_MAX) : div_q[DIST_W-1:0];
    end
    if (cmd.res_none) begin
      res_code <= '0;
      res_dist <= '0;
      res_frac <= '0;
    end
    if (cmd.res_start) begin
      res_code <= HIT_W'(ram_q);
      res_dist <= DIST_W'(START_DIST);
      res_frac <= '0;
    end
    if (cmd.res_hit) begin
      res_code <= HIT_W'(ram_q) + HIT_W'(side);
      res_frac <= frac_c;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      column_out    <= col_r;
      hit_code      <= res_code;
      distance      <= res_dist;
      wall_fraction <= res_frac;
    end
  end

  assign sts.div_busy   = div_busy;
  assign sts.div_done   = div_done;
  assign sts.oob        = oob;
  assign sts.cell_nz    = (ram_q != '0);
  assign sts.zero_ray   = (vx == '0) && (vy == '0);
  assign sts.steps_done = (steps == STEP_W'(MAX_STEPS));
  assign sts.out_free   = !out_valid || out_ready;

endmodule

@@ sv/grc_ctrl.sv @@
// ----------------------------------------------------------------------------
// Grid ray caster controller
// Sequences map writes, ray setup, the cell-by-cell walk, and the hit computations.
// ----------------------------------------------------------------------------
`include "grid_ray_caster_macros.svh"

module grc_ctrl
  import grc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     action,
  output logic     in_ready,
  input  grc_sts_t sts,
  output grc_cmd_t cmd
);

  typedef enum logic [16:0] {
    S_IDLE   = 17'h00001,
    S_DIV_C  = 17'h00002,
    S_WAIT_C = 17'h00004,
    S_MUL_V  = 17'h00008,
    S_SET_V  = 17'h00010,
    S_INIT   = 17'h00020,
    S_MUL_S  = 17'h00040,
    S_ADDR   = 17'h00080,
    S_TEST   = 17'h00100,
    S_STEP   = 17'h00200,
    S_MUL_LO = 17'h00400,
    S_MUL_HI = 17'h00800,
    S_DIV_D  = 17'h01000,
    S_WAIT_D = 17'h02000,
    S_DIV_W  = 17'h04000,
    S_WAIT_W = 17'h08000,
    S_FIN    = 17'h10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   first;
  logic   first_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      first <= 1'b0;
    end else begin
      state <= state_next;
      first <= first_next;
    end
  end

  always_comb begin
    state_next  = state;
    first_next  = first;
    cmd         = '0;
    cmd.div_sel = DIV_SEL_C;
    in_ready    = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (action == ACT_CAST) begin
            cmd.load_col = 1'b1;
            state_next   = S_DIV_C;
          end else begin
            cmd.ram_wr = 1'b1;
          end
        end
      end
      S_DIV_C: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SEL_C;
        state_next    = S_WAIT_C;
      end
      S_WAIT_C: begin
        if (sts.div_done) begin
          cmd.cap_c  = 1'b1;
          state_next = S_MUL_V;
        end
      end
      S_MUL_V: begin
        cmd.mul_v  = 1'b1;
        state_next = S_SET_V;
      end
      S_SET_V: begin
        cmd.set_v  = 1'b1;
        state_next = S_INIT;
      end
      S_INIT: begin
        cmd.init   = 1'b1;
        first_next = 1'b1;
        state_next = S_MUL_S;
      end
      S_MUL_S: begin
        cmd.mul_s  = 1'b1;
        state_next = S_ADDR;
      end
      S_ADDR: begin
        cmd.addr   = 1'b1;
        state_next = S_TEST;
      end
      S_TEST: begin
        // The start cell is tested before the ray is known to be nonzero.
        if (sts.oob) begin
          cmd.res_none = 1'b1;
          state_next   = S_FIN;
        end else if (sts.cell_nz) begin
          if (first) begin
            cmd.res_start = 1'b1;
            state_next    = S_FIN;
          end else begin
            state_next = S_MUL_LO;
          end
        end else if ((first && sts.zero_ray) || (!first && sts.steps_done)) begin
          cmd.res_none = 1'b1;
          state_next   = S_FIN;
        end else begin
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        cmd.step   = 1'b1;
        first_next = 1'b0;
        state_next = S_ADDR;
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_DIV_D;
      end
      S_DIV_D: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SEL_DIST;
        state_next    = S_WAIT_D;
      end
      S_WAIT_D: begin
        if (sts.div_done) begin
          cmd.cap_d  = 1'b1;
          state_next = S_DIV_W;
        end
      end
      S_DIV_W: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SEL_WALL;
        state_next    = S_WAIT_W;
      end
      S_WAIT_W: begin
        cmd.div_sel = DIV_SEL_WALL;
        if (sts.div_done) begin
          cmd.res_hit = 1'b1;
          state_next  = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `GRC_ASSERT(a_div_idle_start, clk, rst, cmd.div_start |-> !sts.div_busy, "divider restarted while busy")
  `GRC_ASSERT(a_done_in_wait, clk, rst, sts.div_done |-> (state == S_WAIT_C || state == S_WAIT_D || state == S_WAIT_W), "divider finished outside a wait state")
  `GRC_ASSERT(a_load_free, clk, rst, cmd.out_load |-> sts.out_free, "result loaded over a pending item")
  `GRC_ASSERT_NR(a_reset_idle, clk, rst |=> (state == S_IDLE), "controller not idle after reset")

endmodule

@@ sv/grid_ray_caster.sv @@
// ----------------------------------------------------------------------------
// Grid ray caster
// DDA ray caster over a tile map held in on-chip memory.
// ----------------------------------------------------------------------------
// Input items arrive on in_valid/in_ready. A write item (action 0) stores
// cell_value at cell_index in the tile map. A cast item (action 1) forms
// the ray for one screen column and walks the map until a nonzero cell,
// the map edge or the step limit, then presents one result item on
// out_valid/out_ready. Items are handled one at a time.
// A cast with a wall hit runs three divisions in the bit-serial divider
// (screen coordinate, distance, wall position), one without a hit runs only
// the first; each grid step includes a read of the map.
// Configuration registers are written on cfg_valid/cfg_ready, always ready,
// and may only change while no cast is in flight.
// The finished result sits in an output register; the next item is accepted
// while it waits. A cast that completes while the receiver stalls holds until
// the output register frees. Reset returns the configuration registers to
// their defaults, clears out_valid and idles the sequencer; the tile map is
// not cleared and must be written before it is read.
// ----------------------------------------------------------------------------
module grid_ray_caster
  import grc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  action,
  input  logic [CIDX_W-1:0]     cell_index,
  input  logic [CVAL_W-1:0]     cell_value,
  input  logic [COL_W-1:0]      column,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COL_W-1:0]      column_out,
  output logic [HIT_W-1:0]      hit_code,
  output logic [DIST_W-1:0]     distance,
  output logic [WF_W-1:0]       wall_fraction,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  grc_cmd_t cmd;
  grc_sts_t sts;

  assign cfg_ready = 1'b1;

  grc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  grc_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cell_index    (cell_index),
    .cell_value    (cell_value),
    .column        (column),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .column_out    (column_out),
    .hit_code      (hit_code),
    .distance      (distance),
    .wall_fraction (wall_fraction)
  );

endmodule
